@@ src/pps_pkg.sv @@
// Shared types and constants for the preemptive priority scheduler.
`timescale 1ns / 1ps

package pps_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int QDEPTH    = 2;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_REJECTED  = 2'd1,
        ST_RAN       = 2'd2,
        ST_IDLE_TICK = 2'd3
    } status_t;

    // Classified command handed from the front queue to the execution side.
    typedef struct packed {
        logic        is_tick;
        logic        slot_ok;
        logic [2:0]  slot;
        logic [7:0]  prio;
        logic [15:0] burst;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  run_slot;
        logic        switched;
        logic        finished;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic [31:0] now_time;
    } res_t;

endpackage

@@ src/sched_req_if.sv @@
// Request channel: arrivals and ticks going into the scheduler.
`timescale 1ns / 1ps

interface sched_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [2:0]  proc_slot;
    logic [7:0]  priority_req;
    logic [15:0] burst;

    modport source (output valid, kind, proc_slot, priority_req, burst, input ready);
    modport sink   (input valid, kind, proc_slot, priority_req, burst, output ready);
endinterface

@@ src/sched_rsp_if.sv @@
// Response channel: one result item per request.
`timescale 1ns / 1ps

interface sched_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  run_slot;
    logic        switched;
    logic        finished;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic [31:0] now_time;

    modport source (output valid, status, run_slot, switched, finished, turnaround,
                    waiting, now_time, input ready);
    modport sink   (input valid, status, run_slot, switched, finished, turnaround,
                    waiting, now_time, output ready);
endinterface

@@ src/pps_front.sv @@
// Front end: classify incoming items and hold them in a short command queue.
`timescale 1ns / 1ps

module pps_front
    import pps_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    sched_req_if.sink   req,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    cmd_t               q_mem_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    cmd_t               cmd_in;
    logic               push;
    logic               pop;

    // Zero burst counts as one; out-of-table slots are flagged here.
    always_comb
    begin
        cmd_in.is_tick = req.kind;
        cmd_in.slot_ok = (32'(req.proc_slot) < 32'(SLOTS));
        cmd_in.slot    = req.proc_slot;
        cmd_in.prio    = req.priority_req;
        cmd_in.burst   = (req.burst == 16'd0) ? 16'd1 : req.burst;
    end

    assign req.ready = (count_reg != CNT_W'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem_reg[rd_ptr_reg];
    assign push      = req.valid && req.ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ src/pps_back.sv @@
// Back end: slot table, best-process scan and result register.
`timescale 1ns / 1ps

module pps_back
    import pps_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    sched_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(SLOTS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_EXEC = 6'b000100,
        S_FIN  = 6'b001000,
        S_WAIT = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [SLOTS-1:0]   busy_reg, busy_next;
    logic [7:0]         prio_mem   [SLOTS];
    logic [15:0]        rem_mem    [SLOTS];
    logic [15:0]        burst_mem  [SLOTS];
    logic [31:0]        arr_mem    [SLOTS];

    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [7:0]         best_prio_reg, best_prio_next;
    logic [31:0]        best_arr_reg, best_arr_next;
    logic [31:0]        clock_reg, clock_next;
    logic               last_valid_reg, last_valid_next;
    logic [IDX_W-1:0]   last_idx_reg, last_idx_next;
    res_t               res_reg, res_next;
    res_t               out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]   widx;
    logic               arr_we;
    logic               rem_we;
    logic [15:0]        rem_dec;
    logic [31:0]        clk_new;
    logic [31:0]        burst32;
    logic               cand;
    logic               load;

    assign cmd_ready = (state_reg == S_IDLE);
    assign widx      = IDX_W'(cmd.slot);
    assign clk_new   = (clock_reg == TIME_MAX) ? clock_reg : clock_reg + 32'd1;
    assign rem_dec   = (rem_mem[best_idx_reg] != 16'd0) ? rem_mem[best_idx_reg] - 16'd1
                                                        : 16'd0;
    assign burst32   = 32'(burst_mem[best_idx_reg]);
    assign load      = (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready);

    // Lower priority value wins, then earlier arrival; equal keeps the lower slot.
    assign cand = busy_reg[scan_reg]
               && (!found_reg
                   || (prio_mem[scan_reg] < best_prio_reg)
                   || ((prio_mem[scan_reg] == best_prio_reg)
                       && (arr_mem[scan_reg] < best_arr_reg)));

    always_comb
    begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        scan_next       = scan_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_arr_next   = best_arr_reg;
        clock_next      = clock_reg;
        last_valid_next = last_valid_reg;
        last_idx_next   = last_idx_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        arr_we          = 1'b0;
        rem_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.is_tick)
                    begin
                        scan_next  = '0;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        res_next          = '0;
                        res_next.now_time = clock_reg;
                        if (cmd.slot_ok && !busy_reg[widx])
                        begin
                            res_next.status = ST_ACCEPTED;
                            arr_we          = 1'b1;
                            busy_next[widx] = 1'b1;
                        end
                        else
                        begin
                            res_next.status = ST_REJECTED;
                        end
                        state_next = S_EMIT;
                    end
                end
            end
            S_SCAN:
            begin
                if (cand)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = scan_reg;
                    best_prio_next = prio_mem[scan_reg];
                    best_arr_next  = arr_mem[scan_reg];
                end
                if (scan_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_EXEC:
            begin
                clock_next        = clk_new;
                res_next          = '0;
                res_next.now_time = clk_new;
                state_next        = S_EMIT;
                if (!found_reg)
                begin
                    res_next.status = ST_IDLE_TICK;
                end
                else
                begin
                    res_next.status   = ST_RAN;
                    res_next.run_slot = 3'(best_idx_reg);
                    res_next.switched = !last_valid_reg || (last_idx_reg != best_idx_reg);
                    last_valid_next   = 1'b1;
                    last_idx_next     = best_idx_reg;
                    rem_we            = 1'b1;
                    if (rem_dec == 16'd0)
                    begin
                        busy_next[best_idx_reg] = 1'b0;
                        res_next.finished       = 1'b1;
                        state_next              = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                res_next.turnaround = clock_reg - best_arr_reg;
                state_next          = S_WAIT;
            end
            S_WAIT:
            begin
                res_next.waiting = (res_reg.turnaround >= burst32)
                                 ? res_reg.turnaround - burst32 : 32'd0;
                state_next       = S_EMIT;
            end
            S_EMIT:
            begin
                if (load)
                begin
                    out_next   = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until taken; a new one may load in the same cycle.
    assign out_valid_next = load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            busy_reg       <= '0;
            scan_reg       <= '0;
            found_reg      <= 1'b0;
            clock_reg      <= '0;
            last_valid_reg <= 1'b0;
            last_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            scan_reg       <= scan_next;
            found_reg      <= found_next;
            clock_reg      <= clock_next;
            last_valid_reg <= last_valid_next;
            last_idx_reg   <= last_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_arr_reg  <= best_arr_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
        if (arr_we)
        begin
            prio_mem[widx]  <= cmd.prio;
            rem_mem[widx]   <= cmd.burst;
            burst_mem[widx] <= cmd.burst;
            arr_mem[widx]   <= clock_reg;
        end
        else if (rem_we)
        begin
            rem_mem[best_idx_reg] <= rem_dec;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.run_slot   = out_reg.run_slot;
    assign rsp.switched   = out_reg.switched;
    assign rsp.finished   = out_reg.finished;
    assign rsp.turnaround = out_reg.turnaround;
    assign rsp.waiting    = out_reg.waiting;
    assign rsp.now_time   = out_reg.now_time;

    a_best_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && found_reg |-> busy_reg[best_idx_reg])
        else $error("scan picked a slot that is not busy");

    a_finish_only_on_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && res_reg.finished |-> res_reg.status == ST_RAN)
        else $error("finished flag without a process run");

    a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> clock_reg >= $past(clock_reg))
        else $error("time went backward");

    a_arrival_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && !cmd.is_tick |=> state_reg == S_EMIT)
        else $error("arrival did not go straight to result");

endmodule

@@ src/preemptive_priority_scheduler.sv @@
// Top level of the preemptive priority scheduler: front queue and execution back end.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    kind, proc_slot, priority_req, burst
//   rsp      out  valid / ready    status, run_slot, switched, finished,
//                                  turnaround, waiting, now_time
//
// An arrival goes from idle straight to the result state in the back end; a tick runs
// the one-slot-per-cycle scan, then executes, and a completion adds turnaround and waiting.
// The front queue holds two items, so up to two requests are accepted while a tick runs.
// Reset clears the slot busy flags, the clock and the last-run record.
// A stalled response holds in the output register; the back end waits there.
`timescale 1ns / 1ps

module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    sched_req_if.sink   req,
    sched_rsp_if.source rsp
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    pps_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    pps_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp       (rsp)
    );

endmodule

@@ test/preemptive_priority_scheduler_tb.sv @@
// Self-checking testbench for the preemptive priority scheduler with a slot-table mirror.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_tb
    import pps_pkg::*;
();

    localparam int   NSLOT        = SLOTS_DEF;
    localparam int   RANDOM_ITEMS = 1100;
    localparam int   CALM_ITEMS   = 120;
    localparam int   PAUSE_AT     = 550;
    localparam int   QUIET_LIMIT  = 1000;
    localparam int   TAIL_CYCLES  = 40;
    localparam logic KIND_ARRIVE  = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    // Mirror of the slot table; predicts one result per accepted request item.
    class sched_mirror;
        bit          busy [NSLOT];
        logic [7:0]  prio [NSLOT];
        logic [15:0] remaining [NSLOT];
        logic [15:0] burst_len [NSLOT];
        logic [31:0] arrived [NSLOT];
        logic [31:0] now;
        int          last_slot;
        res_t        awaited [$];
        int          errors;
        int          ran_count;
        int          done_count;
        int          switch_count;
        int          idle_count;
        int          reject_count;

        function new();
            for (int i = 0; i < NSLOT; i++)
            begin
                busy[i] = 1'b0;
            end
            now       = '0;
            last_slot = NSLOT;
            errors    = 0;
        endfunction

        function bit slot_free(int s);
            return !busy[s];
        endfunction

        function int free_count();
            int n;
            n = 0;
            for (int i = 0; i < NSLOT; i++)
            begin
                if (!busy[i])
                    n++;
            end
            return n;
        endfunction

        // Lower priority value first, then earlier arrival; a full tie favours slot a.
        function bit runs_first(int a, int b);
            if (prio[a] != prio[b])
                return prio[a] < prio[b];
            if (arrived[a] != arrived[b])
                return arrived[a] < arrived[b];
            return 1'b1;
        endfunction

        function void note_request(logic kind, logic [2:0] slot, logic [7:0] p,
                                   logic [15:0] b);
            res_t        r;
            int          best;
            logic [15:0] len;
            logic [31:0] turn;
            r = '0;
            if (kind == KIND_ARRIVE)
            begin
                if (int'(slot) >= NSLOT || busy[slot])
                begin
                    r.status = ST_REJECTED;
                    reject_count++;
                end
                else
                begin
                    // A zero burst still needs one time unit.
                    len             = (b == 16'd0) ? 16'd1 : b;
                    busy[slot]      = 1'b1;
                    prio[slot]      = p;
                    remaining[slot] = len;
                    burst_len[slot] = len;
                    arrived[slot]   = now;
                    r.status        = ST_ACCEPTED;
                end
            end
            else
            begin
                best = NSLOT;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (busy[i] && (best == NSLOT || !runs_first(best, i)))
                        best = i;
                end
                if (now != TIME_MAX)
                    now++;
                if (best == NSLOT)
                begin
                    r.status = ST_IDLE_TICK;
                    idle_count++;
                end
                else
                begin
                    r.status   = ST_RAN;
                    r.run_slot = 3'(best);
                    r.switched = (last_slot != best);
                    if (r.switched)
                        switch_count++;
                    last_slot = best;
                    ran_count++;
                    if (remaining[best] != 16'd0)
                        remaining[best]--;
                    if (remaining[best] == 16'd0)
                    begin
                        busy[best]   = 1'b0;
                        r.finished   = 1'b1;
                        turn         = now - arrived[best];
                        r.turnaround = turn;
                        r.waiting    = (turn >= 32'(burst_len[best])) ?
                                       turn - 32'(burst_len[best]) : 32'd0;
                        done_count++;
                    end
                end
            end
            r.now_time = now;
            awaited.push_back(r);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_response(res_t got);
            res_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: result with none pending, expected nothing, got status %0d",
                         $time, got.status);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report("status", 32'(want.status), 32'(got.status));
            if (got.run_slot !== want.run_slot)
                report("run_slot", 32'(want.run_slot), 32'(got.run_slot));
            if (got.switched !== want.switched)
                report("switched", 32'(want.switched), 32'(got.switched));
            if (got.finished !== want.finished)
                report("finished", 32'(want.finished), 32'(got.finished));
            if (got.turnaround !== want.turnaround)
                report("turnaround", want.turnaround, got.turnaround);
            if (got.waiting !== want.waiting)
                report("waiting", want.waiting, got.waiting);
            if (got.now_time !== want.now_time)
                report("now_time", want.now_time, got.now_time);
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sched_req_if req ();
    sched_rsp_if rsp ();

    preemptive_priority_scheduler #(
        .SLOTS (NSLOT)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #1 clk = ~clk;

    sched_mirror slot_mirror = new();
    bit          calm        = 1'b0;
    bit          gap_mode    = 1'b1;
    bit          stall_mode  = 1'b1;
    int          ready_hold  = 0;
    int          phase_cycles = 0;

    // Response side: check each accepted item, then pick the next ready level.
    always @(posedge clk)
    begin : rsp_side
        res_t got;
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            got            = '0;
            got.status     = status_t'(rsp.status);
            got.run_slot   = rsp.run_slot;
            got.switched   = rsp.switched;
            got.finished   = rsp.finished;
            got.turnaround = rsp.turnaround;
            got.waiting    = rsp.waiting;
            got.now_time   = rsp.now_time;
            slot_mirror.check_response(got);
        end
        phase_cycles++;
        if (phase_cycles == 300)
        begin
            phase_cycles = 0;
            stall_mode   = ($urandom_range(0, 2) != 0);
        end
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (calm || !stall_mode)
            rsp.ready <= 1'b1;
        else if (ready_hold > 0)
        begin
            ready_hold--;
            rsp.ready <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            ready_hold = $urandom_range(0, 6);
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    // End the run when neither channel moves an item for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid === 1'b1 && req.ready === 1'b1) ||
                (rsp.valid === 1'b1 && rsp.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Hold the item until accepted; valid stays high into the next item unless a gap follows.
    task automatic send_item(logic kind, logic [2:0] slot, logic [7:0] p, logic [15:0] b);
        req.valid        <= 1'b1;
        req.kind         <= kind;
        req.proc_slot    <= slot;
        req.priority_req <= p;
        req.burst        <= b;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        slot_mirror.note_request(kind, slot, p, b);
        if (!calm && gap_mode && $urandom_range(0, 4) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (slot_mirror.awaited.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [2:0]  slot;
        logic [7:0]  p;
        logic [15:0] b;
        req.valid        = 1'b0;
        req.kind         = KIND_ARRIVE;
        req.proc_slot    = '0;
        req.priority_req = '0;
        req.burst        = '0;
        rsp.ready        = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: idle tick, zero burst, busy slot, tie breaks, preemption, idle gaps.
        send_item(KIND_TICK,   3'd0, 8'd0,   16'd0);
        send_item(KIND_ARRIVE, 3'd0, 8'd0,   16'd0);
        send_item(KIND_ARRIVE, 3'd0, 8'hFF,  16'hFFFF);
        send_item(KIND_TICK,   3'd7, 8'hFF,  16'hFFFF);
        send_item(KIND_ARRIVE, 3'd7, 8'hFF,  16'd2);
        send_item(KIND_ARRIVE, 3'd3, 8'hFF,  16'd1);
        send_item(KIND_TICK,   3'd0, 8'd0,   16'd0);
        send_item(KIND_TICK,   3'd0, 8'd0,   16'd0);
        send_item(KIND_ARRIVE, 3'd5, 8'd10,  16'd3);
        send_item(KIND_TICK,   3'd0, 8'd0,   16'd0);
        send_item(KIND_TICK,   3'd0, 8'd0,   16'd0);
        send_item(KIND_ARRIVE, 3'd1, 8'd10,  16'd2);
        send_item(KIND_ARRIVE, 3'd5, 8'h55,  16'hAAAA);
        send_item(KIND_TICK,   3'd0, 8'd0,   16'd0);
        send_item(KIND_TICK,   3'd0, 8'd0,   16'd0);
        send_item(KIND_TICK,   3'd0, 8'd0,   16'd0);
        send_item(KIND_TICK,   3'd0, 8'd0,   16'd0);
        send_item(KIND_TICK,   3'd0, 8'd0,   16'd0);
        send_item(KIND_TICK,   3'd0, 8'd0,   16'd0);
        send_item(KIND_ARRIVE, 3'd2, 8'hAA,  16'h0055);
        send_item(KIND_ARRIVE, 3'd6, 8'h55,  16'h00AA);
        send_item(KIND_ARRIVE, 3'd4, 8'h00,  16'h0001);
        send_item(KIND_TICK,   3'd0, 8'd0,   16'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
                gap_mode = ($urandom_range(0, 2) != 0);
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            // Let the scheduler drain completely once mid-run.
            if (i == PAUSE_AT)
                drain();
            if ($urandom_range(0, 99) < 35)
            begin
                slot = 3'($urandom_range(0, NSLOT - 1));
                if (slot_mirror.free_count() > 0 && $urandom_range(0, 4) != 0)
                begin
                    while (!slot_mirror.slot_free(slot))
                        slot = 3'($urandom_range(0, NSLOT - 1));
                end
                p = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
                // Long bursts go only to busy slots, where they get rejected.
                if (!slot_mirror.slot_free(slot))
                    b = 16'($urandom);
                else if ($urandom_range(0, 39) == 0)
                    b = 16'($urandom_range(0, 100));
                else
                    b = 16'($urandom_range(0, 4));
                send_item(KIND_ARRIVE, slot, p, b);
            end
            else
                send_item(KIND_TICK, 3'($urandom), 8'($urandom), 16'($urandom));
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d ticks that ran a process (%0d context switches), %0d idle ticks,",
                 slot_mirror.ran_count, slot_mirror.switch_count, slot_mirror.idle_count);
        $display("%0d completed processes and %0d rejected arrivals.",
                 slot_mirror.done_count, slot_mirror.reject_count);
        if (slot_mirror.errors == 0 && slot_mirror.awaited.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/pps_pkg.sv
src/sched_req_if.sv
src/sched_rsp_if.sv
src/pps_front.sv
src/pps_back.sv
src/preemptive_priority_scheduler.sv
test/preemptive_priority_scheduler_tb.sv
